[rtl/cctct_pkg.sv]
// Shared constants and types for the cycle-count to clock-time converter.
package cctct_pkg;
  localparam int CNT_W = 64;
  localparam int RATE_W = 34;
  localparam int SEC_W = 32;
  localparam int NS_W = 30;
  localparam int OP_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int QUO_W = CNT_W + NS_W;
  localparam int NUM_CELLS = QUO_W;

  localparam logic [OP_W-1:0] OP_REALTIME = 3'd0;
  localparam logic [OP_W-1:0] OP_MONOTONIC = 3'd1;
  localparam logic [OP_W-1:0] OP_BOOTTIME = 3'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EPOCH = 2'd2;

  localparam logic [CNT_W-1:0] NS_PER_SEC = 64'd1000000000;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic              vld;
    logic              inv;
    logic              rt;
    logic [RATE_W-1:0] rate;
    logic [RATE_W:0]   rem;
    logic [CNT_W-1:0]  num;
    logic [QUO_W-1:0]  quo;
    logic [SEC_W-1:0]  epoch;
  } stage_t;
endpackage

[rtl/cctct_cell.sv]
// One restoring-division cell: one quotient bit per enabled cycle, then registered.
module cctct_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  cctct_pkg::stage_t d_in,
  output cctct_pkg::stage_t d_out
);
  import cctct_pkg::*;

  stage_t q_r, q_nxt;
  logic [RATE_W+1:0] trial;
  logic [RATE_W:0] shifted;
  logic [RATE_W:0] rem_base;

  always_comb begin
    rem_base = d_in.rem;
    shifted = {rem_base[RATE_W-1:0], d_in.num[CNT_W-1]};
    trial = {1'b0, shifted} - {2'b00, d_in.rate};
    q_nxt = d_in;
    q_nxt.num = {d_in.num[CNT_W-2:0], 1'b0};
    if (!trial[RATE_W+1]) begin
      q_nxt.rem = trial[RATE_W:0];
      q_nxt.quo = {d_in.quo[QUO_W-2:0], 1'b1};
    end else begin
      q_nxt.rem = shifted;
      q_nxt.quo = {d_in.quo[QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;
endmodule

[rtl/cctct_scale.sv]
// Remainder times 10^9 between the two divider chains, in two registered steps.
module cctct_scale (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  cctct_pkg::stage_t d_in,
  output cctct_pkg::stage_t d_out
);
  import cctct_pkg::*;

  stage_t a_r, b_r, b_nxt;
  logic [CNT_W-1:0] lo_r, hi_r;
  logic [CNT_W-1:0] prod;

  assign prod = lo_r + {hi_r[CNT_W-18:0], 17'd0};

  // Product is below rate * 2^30, so its top bits already form a partial
  // remainder below rate; the 30 ns cells then shift in the low bits.
  always_comb begin
    b_nxt = a_r;
    b_nxt.rem = {1'b0, prod[CNT_W-1:NS_W]};
    b_nxt.num = {prod[NS_W-1:0], {(CNT_W-NS_W){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.vld <= 1'b0;
      b_r.vld <= 1'b0;
    end else if (en) begin
      a_r <= d_in;
      lo_r <= {47'd0, d_in.rem[16:0]} * NS_PER_SEC;
      hi_r <= {47'd0, d_in.rem[RATE_W-1:17]} * NS_PER_SEC;
      b_r <= b_nxt;
    end
  end

  assign d_out = b_r;
endmodule

[rtl/cycle_count_to_clock_time.sv]
// Top level: cycle-counter sample to seconds and nanoseconds converter.
// Usage:
//  Requests arrive on the in_ stream: tuser = op (3 bits), tdata = 64-bit
//  counter sample. Results leave on the out_ stream: tuser = status,
//  tdata = {nanoseconds, seconds}. Registers are written on the cfg_ port:
//  index 0 counter rate, 1 boot count, 2 boot epoch seconds.
//  Throughput: one request per cycle while results are taken. Pipeline:
//  input register, 64 cells for seconds, two-step 10^9 scaling, 30 cells
//  for nanoseconds, output fixup; each divider cell yields one quotient bit.
//  The whole pipeline advances together; when the receiver stalls with a
//  result waiting, the chain freezes and in_tready drops, so nothing is lost.
//  Reset clears all valid bits and restores rate 1, boot count 0, epoch 0.
module cycle_count_to_clock_time (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [cctct_pkg::OP_W-1:0]     in_tuser,   // op
  input  logic [cctct_pkg::CNT_W-1:0]    in_tdata,   // counter_sample
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [0:0]                     out_tuser,  // status
  output logic [63:0]                    out_tdata,  // seconds, nanoseconds, pad
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cctct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cctct_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cctct_pkg::*;

  logic [RATE_W-1:0] rate_r;
  logic [CNT_W-1:0] boot_r;
  logic [SEC_W-1:0] epoch_r;
  logic en;
  stage_t in_r;
  stage_t sc [0:CNT_W];
  stage_t nc [0:NS_W];
  logic out_vld_r;
  logic out_st_r;
  logic [SEC_W-1:0] out_sec_r;
  logic [NS_W-1:0] out_ns_r;

  assign cfg_ready = 1'b1;
  assign en = !out_vld_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= {{(RATE_W-1){1'b0}}, 1'b1};
      boot_r <= '0;
      epoch_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RATE: rate_r <= cfg_data[RATE_W-1:0];
        REG_BOOT_COUNT: boot_r <= cfg_data;
        REG_EPOCH: epoch_r <= cfg_data[SEC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r.vld <= 1'b0;
    end else if (en) begin
      in_r.vld <= in_tvalid;
      in_r.inv <= !(in_tuser == OP_REALTIME || in_tuser == OP_MONOTONIC ||
                    in_tuser == OP_BOOTTIME);
      in_r.rt <= (in_tuser == OP_REALTIME);
      in_r.rate <= (rate_r == '0) ? {{(RATE_W-1){1'b0}}, 1'b1} : rate_r;
      in_r.rem <= '0;
      in_r.num <= (in_tuser == OP_MONOTONIC) ? in_tdata : in_tdata - boot_r;
      in_r.quo <= '0;
      in_r.epoch <= epoch_r;
    end
  end

  assign sc[0] = in_r;
  for (genvar i = 0; i < CNT_W; i++) begin : g_sec
    cctct_cell u_cell (.clk(clk), .rst_n(rst_n), .en(en),
                       .d_in(sc[i]), .d_out(sc[i+1]));
  end

  cctct_scale u_scale (.clk(clk), .rst_n(rst_n), .en(en), .d_in(sc[CNT_W]),
                       .d_out(nc[0]));

  for (genvar j = 0; j < NS_W; j++) begin : g_ns
    cctct_cell u_cell (.clk(clk), .rst_n(rst_n), .en(en),
                       .d_in(nc[j]), .d_out(nc[j+1]));
  end

  // After 30 ns cells the seconds sit in quo bits above the ns bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= nc[NS_W].vld;
      out_st_r <= nc[NS_W].inv;
      if (nc[NS_W].inv) begin
        out_sec_r <= '0;
        out_ns_r <= '0;
      end else begin
        out_sec_r <= nc[NS_W].quo[NS_W +: SEC_W] + (nc[NS_W].rt ? nc[NS_W].epoch : '0);
        out_ns_r <= nc[NS_W].quo[NS_W-1:0];
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser = out_st_r;
  assign out_tdata = {2'b00, out_ns_r, out_sec_r};
endmodule
